@@ rtl/lap_pkg.sv @@
// Shared types and constants of the 3x3 Laplacian edge filter.
`default_nettype none

package lap_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
  } lap_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             last_of_frame;
  } lap_out_t;

  // Per-item control flags from the position tracker
  typedef struct packed {
    logic has_out;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } lap_pos_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } lap_state_e;

endpackage

`default_nettype wire

@@ rtl/lap_line_store.sv @@
// Two line memories (older and newer row) with registered read and write forwarding.
`default_nettype none

module lap_line_store
  import lap_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [PIX_W-1:0] wr_older_i,
  input  wire logic [PIX_W-1:0] wr_newer_i,
  output logic      [PIX_W-1:0] rd_older_o,
  output logic      [PIX_W-1:0] rd_newer_o
);

  logic [PIX_W-1:0] older_mem [DEPTH];
  logic [PIX_W-1:0] newer_mem [DEPTH];
  logic [PIX_W-1:0] rd_older_q;
  logic [PIX_W-1:0] rd_newer_q;
  logic             fwd;

  // write in the same cycle to the same entry wins over the stored value
  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
      newer_mem[wr_addr_i] <= wr_newer_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_older_q <= fwd ? wr_older_i : older_mem[rd_addr_i];
      rd_newer_q <= fwd ? wr_newer_i : newer_mem[rd_addr_i];
    end
  end

  assign rd_older_o = rd_older_q;
  assign rd_newer_o = rd_newer_q;

endmodule

`default_nettype wire

@@ rtl/lap_ctrl.sv @@
// Frame geometry registers, position counters and the position recompute sequencer.
`default_nettype none

module lap_ctrl
  import lap_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1),
  localparam int CW = $clog2(TW + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 acc_i,
  output logic      [AW-1:0]        rd_addr_o,
  output lap_pos_t                  info_o,
  output logic                      idle_o
);

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [TW-1:0]    t_q;
  logic [AW-1:0]    col_q;
  logic [AW-1:0]    cc_q;
  logic [TW-1:0]    cr_q;
  logic [PW-1:0]    wh_q;
  logic [TW-1:0]    thr_q;

  lap_state_e       state_q;
  logic [TW-1:0]    dvd_q;
  logic [TW-1:0]    quo_q;
  logic [WW:0]      rem_q;
  logic [CW-1:0]    cnt_q;

  logic [AW-1:0]    col;
  logic [AW-1:0]    col_nxt;
  logic [WW:0]      rem_sh;
  logic             q_bit;

  // effective geometry: clamp to 1..MAX
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_q);
    end
  end

  // input column and neighbor flags of the output position
  always_comb begin
    col = (WW'(col_q) >= w_eff) ? '0 : col_q;
    col_nxt = (WW'(col) + WW'(1) >= w_eff) ? '0 : AW'(WW'(col) + WW'(1));
    info_o.has_out  = t_q >= (TW'(w_eff) + TW'(1));
    info_o.last     = info_o.has_out && (t_q >= thr_q);
    info_o.top_ok   = cr_q != '0;
    info_o.bot_ok   = (cr_q + TW'(1)) < TW'(h_eff);
    info_o.left_ok  = cc_q != '0;
    info_o.right_ok = (WW'(cc_q) + WW'(1)) < w_eff;
  end

  assign rd_addr_o = col;
  assign idle_o    = state_q == ST_IDLE;

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q[WW-1:0], dvd_q[TW-1]};
    q_bit  = rem_sh >= {1'b0, w_eff};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= WIDTH_RESET;
      cfg_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_w_q <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MUL;
      t_q     <= '0;
      col_q   <= '0;
      cc_q    <= '0;
      cr_q    <= '0;
      wh_q    <= '0;
      thr_q   <= '0;
      dvd_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= ST_MUL;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (acc_i) begin
            if (info_o.last) begin
              t_q   <= '0;
              col_q <= '0;
              cc_q  <= '0;
              cr_q  <= '0;
            end else begin
              t_q   <= t_q + TW'(1);
              col_q <= col_nxt;
              if (info_o.has_out) begin
                if (WW'(cc_q) + WW'(1) >= w_eff) begin
                  cc_q <= '0;
                  cr_q <= cr_q + TW'(1);
                end else begin
                  cc_q <= cc_q + AW'(1);
                end
              end
            end
          end
        end
        ST_MUL: begin
          // frame size and the dividend for the output position
          wh_q    <= PW'(w_eff * h_eff);
          dvd_q   <= info_o.has_out ? (t_q - TW'(w_eff) - TW'(1)) : '0;
          quo_q   <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          thr_q <= TW'(wh_q) + TW'(w_eff);
          if (cnt_q == CW'(TW)) begin
            cc_q    <= rem_q[AW-1:0];
            cr_q    <= quo_q;
            state_q <= ST_IDLE;
          end else begin
            rem_q <= q_bit ? (rem_sh - {1'b0, w_eff}) : rem_sh;
            quo_q <= {quo_q[TW-2:0], q_bit};
            dvd_q <= {dvd_q[TW-2:0], 1'b0};
            cnt_q <= cnt_q + CW'(1);
          end
        end
        default: state_q <= ST_MUL;
      endcase
    end
  end

  // output column stays inside the row while items flow
  a_cc_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (WW'(cc_q) < w_eff))
    else $error("output column beyond frame width");

  // frame end restarts the item count
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && idle_o && info_o.last && !cfg_we_i) |=> (t_q == '0))
    else $error("item count not cleared at frame end");

endmodule

`default_nettype wire

@@ rtl/laplacian_3x3_edge_filter.sv @@
// Top level: 3x3 four-neighbor Laplacian edge filter over a raster pixel stream.
//
// Input channel in_valid_i/in_ready_o carries one item per pixel (func, pixel);
// a drain item (func = 1) counts as a zero pixel. Output channel
// out_valid_o/out_ready_i carries (edge_value, last_of_frame).
// Throughput: one item per clock while the receiver keeps up and no recompute
// runs. An item waits in the middle stage while the two line memories are
// read, then the window shifts and the result lands in the output register.
// The result for a centre pixel comes with the item W+1 places later, so the
// host sends W+1 drain items after the last pixel of a frame.
// Configuration: cfg_we_i writes frame_width (index 0) or frame_height
// (index 1). After reset and after each configuration write the block
// recomputes the output row and column with a serial divider and holds
// in_ready_o low until done (TW-bit dividend; TW = 21 for the default 1024
// x 1024 limits). The line memories are not cleared; border masking hides
// stale data. When the receiver stalls, the output register holds its result
// and the input side keeps accepting only until the middle stage is full.
`default_nettype none

module laplacian_3x3_edge_filter
  import lap_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lap_in_t              in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lap_out_t                  out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             acc;
  logic             ctrl_idle;
  logic [AW-1:0]    rd_addr;
  lap_pos_t         info;

  logic             s1_v_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_col_q;
  lap_pos_t         s1_info_q;
  logic             s1_fire;

  logic [PIX_W-1:0] rd_older, rd_newer;

  // window taps that feed the kernel: right column and middle row
  logic [PIX_W-1:0] win_top_q, win_bot_q, win_mid1_q, win_mid2_q;

  logic             out_v_q;
  lap_out_t         out_q;

  logic signed [11:0] sum;
  logic [PIX_W-1:0]   up_v, dn_v, lf_v, rt_v, edge_v;

  // handshake
  assign s1_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = ctrl_idle && (!s1_v_q || s1_fire);
  assign acc        = in_valid_i && in_ready_o;

  lap_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .acc_i      (acc),
    .rd_addr_o  (rd_addr),
    .info_o     (info),
    .idle_o     (ctrl_idle)
  );

  lap_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_older_i(rd_newer),
    .wr_newer_i(s1_pix_q),
    .rd_older_o(rd_older),
    .rd_newer_o(rd_newer)
  );

  // middle stage: waits for the line memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= (in_item_i.func == FUNC_DRAIN) ? '0 : in_item_i.pixel;
      s1_col_q  <= rd_addr;
      s1_info_q <= info;
    end
  end

  // kernel on the window after this item's shift, with border masks
  always_comb begin
    up_v = s1_info_q.top_ok   ? win_top_q  : '0;
    dn_v = s1_info_q.bot_ok   ? win_bot_q  : '0;
    lf_v = s1_info_q.left_ok  ? win_mid1_q : '0;
    rt_v = s1_info_q.right_ok ? rd_newer   : '0;
    sum  = $signed({4'd0, up_v}) + $signed({4'd0, dn_v}) + $signed({4'd0, lf_v})
         + $signed({4'd0, rt_v}) - $signed({2'd0, win_mid2_q, 2'd0});
    if (sum < 0) begin
      edge_v = '0;
    end else if (sum > $signed({4'd0, EDGE_MAX})) begin
      edge_v = EDGE_MAX;
    end else begin
      edge_v = sum[PIX_W-1:0];
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top_q  <= '0;
      win_bot_q  <= '0;
      win_mid1_q <= '0;
      win_mid2_q <= '0;
    end else if (s1_fire) begin
      win_top_q  <= rd_older;
      win_bot_q  <= s1_pix_q;
      win_mid1_q <= win_mid2_q;
      win_mid2_q <= rd_newer;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire && s1_info_q.has_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_info_q.has_out) begin
      out_q.edge_value    <= edge_v;
      out_q.last_of_frame <= s1_info_q.last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // no item is taken while the position is being recomputed
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_idle |-> !in_ready_o)
    else $error("item accepted during position recompute");

  // a stalled middle stage keeps its item and its memory address
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_fire) |=> (s1_v_q && $stable(s1_col_q)))
    else $error("middle stage lost its item");

endmodule

`default_nettype wire

@@ test/laplacian_checker.sv @@
`timescale 1ns / 1ps
// Checker for the Laplacian edge filter: predicts each result from the accepted items and compares.
module laplacian_checker
  import lap_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  lap_in_t              in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  lap_out_t             out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   results_o,
  output int                   frames_o
);

  // Shadow of the filter state
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [PIX_W-1:0] row_older [MAX_WIDTH];
  logic [PIX_W-1:0] row_newer [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];  // [row][col], col 0 oldest, row 0 top
  int unsigned      col_pos;
  int unsigned      taken;

  lap_out_t edge_expected_q [$];
  lap_out_t want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
    frames_o     = 0;
    col_pos      = 0;
    taken        = 0;
    cfg_width    = WIDTH_RESET;
    cfg_height   = HEIGHT_RESET;
    // never-written line entries only reach masked taps, any value works
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_older[i] = '0;
      row_newer[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win[r][c] = '0;
      end
    end
  end

  // Out-of-range sizes act as the nearest legal size
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Push one item through the line stores and window; queue its edge result if one is due
  task automatic advance_filter(input lap_in_t item);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      t;
    int unsigned      p;
    int unsigned      cr;
    int unsigned      cc;
    int               acc;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    lap_out_t         res;
    w  = clamp_dim(cfg_width, MAX_WIDTH);
    h  = clamp_dim(cfg_height, MAX_HEIGHT);
    px = (item.func == FUNC_DRAIN) ? '0 : item.pixel;
    c  = (col_pos >= w) ? 0 : col_pos;
    up  = row_older[c];
    mid = row_newer[c];
    row_older[c] = mid;
    row_newer[c] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    col_pos = (c + 1 >= w) ? 0 : c + 1;

    t     = taken;
    taken = t + 1;
    if (t >= w + 1) begin
      // centre sits w+1 items back
      p   = t - w - 1;
      cr  = p / w;
      cc  = p % w;
      acc = -4 * int'(win[1][1]);
      if (cr > 0)     acc = acc + int'(win[0][1]);
      if (cr + 1 < h) acc = acc + int'(win[2][1]);
      if (cc > 0)     acc = acc + int'(win[1][0]);
      if (cc + 1 < w) acc = acc + int'(win[1][2]);
      if (acc < 0)   acc = 0;
      if (acc > 255) acc = 255;
      res.edge_value    = acc[PIX_W-1:0];
      res.last_of_frame = (p + 1 >= w * h);
      if (res.last_of_frame) begin
        taken   = 0;
        col_pos = 0;
        frames_o++;
      end
      edge_expected_q.push_back(res);
      pending_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
    end else begin
      // compare each result against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (edge_expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, got edge %0d last %0b",
                   $time, out_item_i.edge_value, out_item_i.last_of_frame);
        end else begin
          want = edge_expected_q.pop_front();
          pending_o--;
          if (out_item_i.edge_value !== want.edge_value) begin
            fail_count_o++;
            $display("%0t: edge_value mismatch: expected %0d, got %0d",
                     $time, want.edge_value, out_item_i.edge_value);
          end
          if (out_item_i.last_of_frame !== want.last_of_frame) begin
            fail_count_o++;
            $display("%0t: last_of_frame mismatch: expected %0b, got %0b",
                     $time, want.last_of_frame, out_item_i.last_of_frame);
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  cfg_width  = cfg_wdata_i;
          CFG_FRAME_HEIGHT: cfg_height = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_filter(in_item_i);
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives frames and size settings into the Laplacian filter and reports the verdict.
module tb_top;
  import lap_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int RAND_ITEMS    = 1650;
  localparam int MAX_WAIT      = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int IDLE_LIMIT    = 4000;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_CUT,
    FRAME_SHORT_DRAIN,
    FRAME_NOISE
  } frame_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  lap_in_t              in_item   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_ready;
  logic                 out_valid;
  lap_out_t             out_item;

  int fail_count;
  int pending_edges;
  int results_seen;
  int frames_seen;
  int items_sent    = 0;
  int settings_used = 0;
  int holds_done    = 0;
  int idle_cycles   = 0;
  bit tx_gaps       = 1'b1;
  bit rx_stalls     = 1'b1;
  bit rx_hold       = 1'b0;

  laplacian_3x3_edge_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  laplacian_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_edges),
    .results_o    (results_seen),
    .frames_o     (frames_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: ends the run after too long without any handshake or write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_edges);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls per item, plus an occasional long hold-off
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
        holds_done++;
      end
      stall = rx_stalls ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic int eff_dim(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
    case (mode)
      0:       return $urandom_range(0, 255);
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return 8'd120 + $urandom_range(0, 16);   // flat area, small responses
      default: return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic send_item(input logic func, input logic [PIX_W-1:0] pix);
    int      gap;
    lap_in_t item;
    gap        = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    item.func  = func;
    item.pixel = pix;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result is out
  task automatic wait_drained;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_edges != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    wait_drained();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    settings_used++;
  endtask

  // One frame with w+1 trailing drains, or a deliberately broken variant
  task automatic send_frame(input int w, input int h, input frame_kind_e kind, input int mode);
    int n_pix;
    int n_drain;
    n_pix   = w * h;
    n_drain = w + 1;
    case (kind)
      FRAME_CUT: begin
        n_pix   = $urandom_range(1, n_pix);
        n_drain = 0;
      end
      FRAME_SHORT_DRAIN: n_drain = $urandom_range(0, w);
      FRAME_NOISE: begin
        n_pix   = $urandom_range(1, w + 3);
        n_drain = 0;
      end
      default: ;
    endcase
    repeat (n_pix) begin
      if (kind == FRAME_NOISE) begin
        send_item($urandom_range(0, 1), $urandom_range(0, 255));
      end else if ($urandom_range(0, 39) == 0) begin
        send_item(FUNC_DRAIN, $urandom_range(0, 255));  // early drain
      end else begin
        send_item(FUNC_PIXEL, pick_pixel(mode));
      end
    end
    repeat (n_drain) send_item(FUNC_DRAIN, $urandom_range(0, 255));
  endtask

  initial begin
    int          w_raw;
    int          h_raw;
    int          w;
    int          h;
    int          sel;
    int          phase;
    int          n_frames;
    int          rand_end;
    bit          cut;
    frame_kind_e kind;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 3x3 frame of alternating extremes, last pixel an early drain
    set_frame(3, 3);
    repeat (4) begin
      send_item(FUNC_PIXEL, 8'hFF);
      send_item(FUNC_PIXEL, 8'h00);
    end
    send_item(FUNC_DRAIN, 8'hAA);
    repeat (4) send_item(FUNC_DRAIN, 8'h55);

    // Zero width and oversized height, then shrink the height mid-frame
    set_frame(0, 2047);
    send_item(FUNC_PIXEL, 8'h00);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h80);
    send_item(FUNC_PIXEL, 8'h7F);
    send_item(FUNC_PIXEL, 8'h01);
    wait_drained();
    cfg_write(CFG_FRAME_HEIGHT, 3);
    send_item(FUNC_PIXEL, 8'hC3);

    // Single-pixel frame from a zero height
    set_frame(1, 0);
    send_item(FUNC_PIXEL, 8'h3C);
    repeat (2) send_item(FUNC_DRAIN, 8'h00);

    // One full-width frame from an oversized width, with a long output hold
    set_frame(2047, 1);
    tx_gaps = 1'b0;
    rx_hold = 1'b1;
    send_frame(MAX_DIM, 1, FRAME_CLEAN, 0);
    tx_gaps = 1'b1;

    // Random phases: mostly small frames, new sizes each phase
    rand_end = items_sent + RAND_ITEMS;
    phase    = 0;
    while (items_sent < rand_end) begin
      sel   = $urandom_range(0, 99);
      w_raw = (sel < 5) ? 0 : (sel < 60) ? $urandom_range(1, 4) :
              (sel < 90) ? $urandom_range(5, 12) : $urandom_range(13, 40);
      h_raw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      if (phase == 4) begin
        w_raw = 16;
        h_raw = 4;
      end
      set_frame(w_raw, h_raw);
      w         = eff_dim(w_raw);
      h         = eff_dim(h_raw);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      if (phase == 4) begin
        // back-to-back items against a stalled receiver
        tx_gaps = 1'b0;
        rx_hold = 1'b1;
      end
      n_frames = $urandom_range(1, 3);
      cut      = 1'b0;
      while (n_frames > 0 && !cut) begin
        sel = $urandom_range(0, 9);
        if (sel < 7)       kind = FRAME_CLEAN;
        else if (sel == 7) kind = FRAME_CUT;
        else if (sel == 8) kind = FRAME_SHORT_DRAIN;
        else               kind = FRAME_NOISE;
        send_frame(w, h, kind, $urandom_range(0, 3));
        cut = (kind == FRAME_CUT);  // next phase resizes mid-frame
        n_frames--;
      end
      phase++;
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("Run covered %0d items over %0d size settings: %0d results, %0d frames ended",
             items_sent, settings_used, results_seen, frames_seen);
    $display("Widths and heights from 1 to the maximum incl. out-of-range writes; %0d long holds",
             holds_done);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
